// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/u2a_pkg.sv -----
// types and constants shared by the utf-8 to ascii sanitizer
package u2a_pkg;

  localparam int COUNT_BITS = 12;
  localparam int LIMIT_W    = 12;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(2044);
  localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;

  localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd0;

  localparam logic [7:0] B_ASCII_TOP = 8'h80;
  localparam logic [7:0] B_E2        = 8'hE2;
  localparam logic [7:0] B_80        = 8'h80;
  localparam logic [7:0] B_93        = 8'h93;
  localparam logic [7:0] B_94        = 8'h94;
  localparam logic [7:0] B_98        = 8'h98;
  localparam logic [7:0] B_99        = 8'h99;
  localparam logic [7:0] B_9C        = 8'h9C;
  localparam logic [7:0] B_9D        = 8'h9D;
  localparam logic [7:0] B_A6        = 8'hA6;
  localparam logic [7:0] B_C2        = 8'hC2;
  localparam logic [7:0] B_A0        = 8'hA0;
  localparam logic [7:0] B_F0        = 8'hF0;
  localparam logic [7:0] B_E0        = 8'hE0;
  localparam logic [7:0] B_C0        = 8'hC0;

  localparam logic [6:0] CH_DASH  = 7'h2D;
  localparam logic [6:0] CH_APOS  = 7'h27;
  localparam logic [6:0] CH_QUOTE = 7'h22;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_NUL   = 7'h00;

  typedef enum logic [1:0] {
    PK_IDLE,
    PK_E2,
    PK_E280,
    PK_C2
  } pend_t;

  typedef struct packed {
    pend_t                 pk;
    logic [1:0]            drop;
    logic [COUNT_BITS-1:0] cnt;
    logic                  lim;
  } txt_st_t;

  typedef struct packed {
    logic [6:0] chr;
    logic [1:0] nchar;
    logic       eot;
  } grp_t;

endpackage

// ----- sv/u2a_decode.sv -----
// per-byte decode of the pending sequence state into a result group
module u2a_decode import u2a_pkg::*; (
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  txt_st_t            st_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output txt_st_t            st_o,
  output grp_t               grp_o
);

  logic                  at_limit;
  logic [COUNT_BITS:0]   cnt_sum;
  txt_st_t               st_a;

  assign at_limit = (CMP_W'(st_i.cnt) >= CMP_W'(limit_i)) || (st_i.cnt == CNT_MAX);

  always_comb begin
    st_a        = st_i;
    grp_o.chr   = CH_NUL;
    grp_o.nchar = 2'd0;
    grp_o.eot   = 1'b0;
    if (byte_i != 8'h00 && !st_i.lim) begin
      if (st_i.drop != 2'd0) begin
        st_a.drop = st_i.drop - 2'd1;
      end else begin
        unique case (st_i.pk)
          PK_E2: begin
            if (byte_i == B_80) begin
              st_a.pk = PK_E280;
            end else begin
              st_a.pk   = PK_IDLE;
              st_a.drop = 2'd1;
            end
          end
          PK_E280: begin
            st_a.pk = PK_IDLE;
            if (byte_i == B_93 || byte_i == B_94) begin
              grp_o.chr   = CH_DASH;
              grp_o.nchar = 2'd1;
            end else if (byte_i == B_98 || byte_i == B_99) begin
              grp_o.chr   = CH_APOS;
              grp_o.nchar = 2'd1;
            end else if (byte_i == B_9C || byte_i == B_9D) begin
              grp_o.chr   = CH_QUOTE;
              grp_o.nchar = 2'd1;
            end else if (byte_i == B_A6) begin
              grp_o.chr   = CH_DOT;
              grp_o.nchar = 2'd3;
            end
          end
          PK_C2: begin
            st_a.pk = PK_IDLE;
            if (byte_i == B_A0) begin
              grp_o.chr   = CH_SPACE;
              grp_o.nchar = 2'd1;
            end
          end
          PK_IDLE: begin
            if (at_limit) begin
              st_a.lim = 1'b1;
            end else if (byte_i < B_ASCII_TOP) begin
              grp_o.chr   = byte_i[6:0];
              grp_o.nchar = 2'd1;
            end else if (byte_i == B_E2) begin
              st_a.pk = PK_E2;
            end else if (byte_i == B_C2) begin
              st_a.pk = PK_C2;
            end else if (byte_i >= B_F0) begin
              st_a.drop = 2'd3;
            end else if (byte_i >= B_E0) begin
              st_a.drop = 2'd2;
            end else if (byte_i >= B_C0) begin
              st_a.drop = 2'd1;
            end
          end
          default: st_a.pk = PK_IDLE;
        endcase
      end
    end
    cnt_sum  = {1'b0, st_i.cnt} + (COUNT_BITS+1)'(grp_o.nchar);
    st_a.cnt = cnt_sum[COUNT_BITS] ? CNT_MAX : cnt_sum[COUNT_BITS-1:0];
    if (byte_i == 8'h00 || last_i) begin
      grp_o.eot = 1'b1;
      st_o      = '{pk: PK_IDLE, drop: 2'd0, cnt: '0, lim: 1'b0};
    end else begin
      st_o = st_a;
    end
  end

endmodule

// ----- sv/u2a_emit.sv -----
// result register that plays a decoded group out one item per cycle while out_stall is low
module u2a_emit import u2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  grp_t       grp_i,
  output logic       ready_o,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       out_end_of_text,
  output logic       out_run_last
);

  logic       vld_r, vld_nxt;
  logic [6:0] chr_r, chr_nxt;
  logic [1:0] left_r, left_nxt;
  logic       eot_r, eot_nxt;
  logic       fire;
  logic       last_beat;

  assign fire      = vld_r && !out_stall;
  assign last_beat = (left_r == 2'd1 && !eot_r) || (left_r == 2'd0);
  assign ready_o   = !vld_r || (fire && last_beat);

  assign out_valid       = vld_r;
  assign out_char        = (left_r != 2'd0) ? chr_r : CH_NUL;
  assign out_end_of_text = (left_r == 2'd0);
  assign out_run_last    = last_beat;

  always_comb begin
    vld_nxt  = vld_r;
    chr_nxt  = chr_r;
    left_nxt = left_r;
    eot_nxt  = eot_r;
    if (load_i) begin
      vld_nxt  = 1'b1;
      chr_nxt  = grp_i.chr;
      left_nxt = grp_i.nchar;
      eot_nxt  = grp_i.eot;
    end else if (fire) begin
      if (last_beat) begin
        vld_nxt = 1'b0;
      end else begin
        left_nxt = left_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    chr_r  <= chr_nxt;
    left_r <= left_nxt;
    eot_r  <= eot_nxt;
  end

endmodule

// ----- sv/utf8_to_ascii_text_sanitizer.sv -----
// utf-8 to ascii text sanitizer, top level
// an accepted byte is held in byte_r and decoded, and its items wait in the result register
// throughput: one byte per cycle while out_stall is low and each byte gives at most one item;
//   a byte giving more than one item stalls the input until its last item is taken
// reset: synchronous active-low rst_n clears all text state, limit returns to 2044
module utf8_to_ascii_text_sanitizer import u2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_char,
  output logic        out_end_of_text,
  output logic        out_run_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "assert_macros.svh"

  logic               in_vld_r;
  logic [7:0]         byte_r;
  logic               last_r;
  txt_st_t            st_r, st_nxt;
  logic [LIMIT_W-1:0] limit_r;
  grp_t               grp;
  logic               emit_ready;
  logic               has_items;
  logic               dec_take;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_OUTPUT_LIMIT) ? 32'(limit_r) : 32'd0;

  assign has_items = grp.eot || (grp.nchar != 2'd0);
  assign dec_take  = in_vld_r && (!has_items || emit_ready);
  assign in_stall  = in_vld_r && !dec_take;

  u2a_decode u_decode (
    .byte_i  (byte_r),
    .last_i  (last_r),
    .st_i    (st_r),
    .limit_i (limit_r),
    .st_o    (st_nxt),
    .grp_o   (grp)
  );

  u2a_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load_i          (dec_take && has_items),
    .grp_i           (grp),
    .ready_o         (emit_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_end_of_text (out_end_of_text),
    .out_run_last    (out_run_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '{pk: PK_IDLE, drop: 2'd0, cnt: '0, lim: 1'b0};
      limit_r  <= LIMIT_RESET;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (dec_take) begin
        st_r <= st_nxt;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_OUTPUT_LIMIT) begin
        limit_r <= cfg_pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= in_byte;
      last_r <= in_is_last;
    end
  end

  `ASSERT_CLK(a_eot_last, clk, rst_n, out_valid && out_end_of_text |-> out_run_last, "terminator item not marked last")
  `ASSERT_CLK(a_char_nonzero, clk, rst_n, out_valid && !out_end_of_text |-> out_char != CH_NUL, "zero character outside terminator")
  `ASSERT_NEVER(a_drop_idle, clk, rst_n, st_r.drop != 2'd0 && st_r.pk != PK_IDLE, "drop count set with sequence pending")

endmodule

// ----- sim/utf8_to_ascii_text_sanitizer_tb.sv -----
// testbench for the utf-8 to ascii sanitizer: directed and random text checked by a predictor
`timescale 1ns / 1ps

module utf8_to_ascii_text_sanitizer_tb;
  import u2a_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 32;

  typedef struct packed {
    logic [6:0] ch;
    logic       eot;
    logic       rl;
  } ascii_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic       has_ch;
    logic [6:0] ch;
    logic       term;
  } dir_row_t;

  // byte, last, typed, char present, char, terminator
  localparam dir_row_t DIRECTED [24] = '{
    '{8'h41, 1'b0, 1'b1, 1'b1, 7'h41,  1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, CH_NUL, 1'b1},
    '{8'h7F, 1'b0, 1'b1, 1'b1, 7'h7F,  1'b0},
    '{8'h01, 1'b1, 1'b1, 1'b1, 7'h01,  1'b1},
    '{B_E2,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_80,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_93,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_E2,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_80,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_A6,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_C2,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_A0,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_C2,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_E2,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{8'h42, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_E2,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{B_80,  1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, CH_NUL, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, CH_NUL, 1'b1},
    '{B_E2,  1'b1, 1'b1, 1'b0, CH_NUL, 1'b1},
    '{8'h80, 1'b0, 1'b1, 1'b0, CH_NUL, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_char;
  logic        out_end_of_text;
  logic        out_run_last;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  utf8_to_ascii_text_sanitizer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_end_of_text (out_end_of_text),
    .out_run_last    (out_run_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always #5 clk = ~clk;

  // text decoder state mirrored here
  pend_t                 txt_pk    = PK_IDLE;
  logic [1:0]            txt_drop  = '0;
  logic [COUNT_BITS-1:0] txt_cnt   = '0;
  logic                  txt_lim   = 1'b0;
  logic [LIMIT_W-1:0]    cur_limit = LIMIT_RESET;

  ascii_item_t byte_chars_q [$];
  ascii_item_t ascii_out_q [$];
  ascii_item_t due;

  int gap_pct    = 0;
  int stall_pct  = 0;
  int sent_items = 0;
  int mismatches = 0;
  int cycles     = 0;

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    mismatches++;
  endtask

  task add_char(input logic [6:0] ch, input logic eot);
    byte_chars_q.push_back('{ch, eot, 1'b0});
    if (!eot && txt_cnt != CNT_MAX) txt_cnt = txt_cnt + 1'b1;
  endtask

  task sanitize_byte(input logic [7:0] b, input logic last);
    ascii_item_t tail;
    if (b != 8'h00 && !txt_lim) begin
      if (txt_drop != 2'd0) begin
        txt_drop = txt_drop - 2'd1;
      end else begin
        unique case (txt_pk)
          PK_E2: begin
            if (b == B_80) begin
              txt_pk = PK_E280;
            end else begin
              txt_pk   = PK_IDLE;
              txt_drop = 2'd1;
            end
          end
          PK_E280: begin
            txt_pk = PK_IDLE;
            unique case (b)
              B_93, B_94: add_char(CH_DASH, 1'b0);
              B_98, B_99: add_char(CH_APOS, 1'b0);
              B_9C, B_9D: add_char(CH_QUOTE, 1'b0);
              B_A6: begin
                add_char(CH_DOT, 1'b0);
                add_char(CH_DOT, 1'b0);
                add_char(CH_DOT, 1'b0);
              end
              default: ;
            endcase
          end
          PK_C2: begin
            txt_pk = PK_IDLE;
            if (b == B_A0) add_char(CH_SPACE, 1'b0);
          end
          default: begin
            txt_pk = PK_IDLE;
            if (txt_cnt >= cur_limit || txt_cnt == CNT_MAX) txt_lim = 1'b1;
            else if (b < B_ASCII_TOP) add_char(b[6:0], 1'b0);
            else if (b == B_E2) txt_pk = PK_E2;
            else if (b == B_C2) txt_pk = PK_C2;
            else if (b >= B_F0) txt_drop = 2'd3;
            else if (b >= B_E0) txt_drop = 2'd2;
            else if (b >= B_C0) txt_drop = 2'd1;
          end
        endcase
      end
    end
    if (b == 8'h00 || last) begin
      add_char(CH_NUL, 1'b1);
      txt_pk   = PK_IDLE;
      txt_drop = '0;
      txt_cnt  = '0;
      txt_lim  = 1'b0;
    end
    if (byte_chars_q.size() != 0) begin
      tail = byte_chars_q.pop_back();
      tail.rl = 1'b1;
      byte_chars_q.push_back(tail);
    end
  endtask

  // called just after a falling edge, returns just after a falling edge
  task automatic send_item(input logic [7:0] b, input logic last, input logic keep);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    sanitize_byte(b, last);
    if (keep) begin
      while (byte_chars_q.size() != 0) ascii_out_q.push_back(byte_chars_q.pop_front());
    end else begin
      byte_chars_q.delete();
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ascii_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= 2'(4 * REG_OUTPUT_LIMIT);
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_output_limit(input logic [LIMIT_W-1:0] val);
    logic [31:0] rd;
    drain();
    cfg_xfer(1'b1, 32'(val), rd);
    cur_limit = val;
    cfg_xfer(1'b0, 32'h0, rd);
    if (rd !== 32'(val)) report_mismatch("output_limit readback", rd, 32'(val));
  endtask

  task automatic send_text();
    logic [7:0] text_q [$];
    int         pick;
    int         ending;
    int         extra;
    if ($urandom_range(0, 19) == 0) drain();
    repeat ($urandom_range(1, 12)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        text_q.push_back(8'($urandom_range(1, 127)));
      end else if (pick < 60) begin
        text_q.push_back(B_E2);
        text_q.push_back(B_80);
        case ($urandom_range(0, 6))
          0: text_q.push_back(B_93);
          1: text_q.push_back(B_94);
          2: text_q.push_back(B_98);
          3: text_q.push_back(B_99);
          4: text_q.push_back(B_9C);
          5: text_q.push_back(B_9D);
          default: text_q.push_back(B_A6);
        endcase
      end else if (pick < 70) begin
        text_q.push_back(B_C2);
        text_q.push_back(B_A0);
      end else if (pick < 78) begin
        // broken three byte sequence, second byte not a continuation of E2
        text_q.push_back(B_E2);
        text_q.push_back(8'($urandom_range(129, 255)));
        text_q.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 84) begin
        text_q.push_back(B_E2);
        text_q.push_back(B_80);
        text_q.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 90) begin
        text_q.push_back(B_C2);
        text_q.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 97) begin
        text_q.push_back(8'($urandom_range(128, 255)));
        extra = $urandom_range(0, 3);
        repeat (extra) text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // sometimes drop the last byte, which can cut the text inside a sequence
    if (text_q.size() > 1 && $urandom_range(0, 6) == 0) void'(text_q.pop_back());
    ending = $urandom_range(0, 99);
    if (ending >= 50) text_q.push_back(8'h00);
    foreach (text_q[i]) begin
      send_item(text_q[i], (i == text_q.size() - 1) && (ending < 50 || ending >= 85), 1'b1);
    end
  endtask

  task automatic run_texts(input int n);
    int target;
    target = sent_items + n;
    while (sent_items < target) send_text();
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ascii_out_q.size() == 0) begin
        report_mismatch("unexpected result, char", 32'(out_char), 32'h0);
      end else begin
        due = ascii_out_q.pop_front();
        if (out_char !== due.ch) report_mismatch("out_char", 32'(out_char), 32'(due.ch));
        if (out_end_of_text !== due.eot) begin
          report_mismatch("out_end_of_text", 32'(out_end_of_text), 32'(due.eot));
        end
        if (out_run_last !== due.rl) begin
          report_mismatch("out_run_last", 32'(out_run_last), 32'(due.rl));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    dir_row_t    row;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    in_is_last  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_xfer(1'b0, 32'h0, rd);
    if (rd !== 32'(LIMIT_RESET)) report_mismatch("output_limit after reset", rd, 32'(LIMIT_RESET));

    gap_pct   = 22;
    stall_pct = 50;
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      send_item(row.b, row.last, !row.typed);
      if (row.typed) begin
        if (row.has_ch) ascii_out_q.push_back('{row.ch, 1'b0, !row.term});
        if (row.term) ascii_out_q.push_back('{CH_NUL, 1'b1, 1'b1});
      end
    end

    set_output_limit(12'd0);
    run_texts(PHASE_ITEMS);
    set_output_limit(12'd1);
    run_texts(PHASE_ITEMS);

    gap_pct   = 50;
    stall_pct = 22;
    set_output_limit(12'd3);
    run_texts(PHASE_ITEMS);
    set_output_limit(12'($urandom_range(2, 12)));
    run_texts(PHASE_ITEMS);

    gap_pct   = 0;
    stall_pct = 0;
    set_output_limit(12'd4092);
    run_texts(PHASE_ITEMS);
    run_texts(PHASE_ITEMS / 2);

    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/u2a_pkg.sv
sv/u2a_decode.sv
sv/u2a_emit.sv
sv/utf8_to_ascii_text_sanitizer.sv
sim/utf8_to_ascii_text_sanitizer_tb.sv
